@@ rtl/core/art_pkg.sv @@
package art_pkg;

    localparam int ADDR_W    = 64;
    localparam int PROT_W    = 3;
    localparam int FLAGS_W   = 32;
    localparam int CNT_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [ADDR_W-1:0] RESET_MIN_ADDRESS = 64'hffff_8000_0000_0000;
    localparam logic [ADDR_W-1:0] RESET_MAX_ADDRESS = 64'hffff_ffff_ffff_ffff;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS = 1'b1;

    typedef enum logic [1:0] {
        ACT_ENTER    = 2'd0,
        ACT_LOOKUP   = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_RESERVED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2
    } status_t;

    typedef struct packed {
        action_t              action;
        logic [ADDR_W-1:0]    address;
        logic [ADDR_W-1:0]    size;
        logic [PROT_W-1:0]    prot;
        logic [PROT_W-1:0]    prot_limit;
        logic [FLAGS_W-1:0]   flags;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic                 found;
        logic [ADDR_W-1:0]    region_start;
        logic [ADDR_W-1:0]    region_end;
        logic [PROT_W-1:0]    region_prot;
        logic [PROT_W-1:0]    region_prot_limit;
        logic [FLAGS_W-1:0]   region_flags;
        logic [CNT_W-1:0]     removed_count;
        logic [CNT_W-1:0]     occupied_count;
    } out_item_t;

    typedef struct packed {
        logic                 valid;
        logic [FLAGS_W-1:0]   flags;
        logic [PROT_W-1:0]    prot_limit;
        logic [PROT_W-1:0]    prot;
        logic [ADDR_W-1:0]    end_addr;
        logic [ADDR_W-1:0]    start_addr;
    } slot_t;

    typedef enum logic [2:0] {
        SEQ_CLEAR  = 3'd0,
        SEQ_IDLE   = 3'd1,
        SEQ_CHECK  = 3'd2,
        SEQ_SCAN   = 3'd3,
        SEQ_COMMIT = 3'd4
    } seq_state_t;

    typedef struct packed {
        logic ready;
        logic clearing;
        logic check;
        logic scan_issue;
        logic cmp_valid;
        logic commit;
    } seq_ctrl_t;

    typedef struct packed {
        logic accept;
        logic skip;
        logic out_free;
    } seq_stat_t;

endpackage

@@ rtl/core/art_stream_if.sv @@
interface art_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/art_ram.sv @@
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/art_cmp.sv @@
// Range test shared by enter, lookup and remove: lo < slot_end and slot_start below hi
// (or at hi when incl is set, which turns it into a point lookup).
module art_cmp (
    input  logic [art_pkg::ADDR_W-1:0] lo,
    input  logic [art_pkg::ADDR_W-1:0] hi,
    input  logic                       incl,
    input  logic [art_pkg::ADDR_W-1:0] slot_start,
    input  logic [art_pkg::ADDR_W-1:0] slot_end,
    output logic                       match
);

    logic below_end;
    logic start_ok;

    assign below_end = lo < slot_end;
    assign start_ok  = incl ? (slot_start <= hi) : (slot_start < hi);
    assign match     = below_end && start_ok;

endmodule

@@ rtl/core/art_seq.sv @@
module art_seq #(
    parameter int SLOTS = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  art_pkg::seq_stat_t        stat,
    output art_pkg::seq_ctrl_t        ctrl,
    output logic [$clog2(SLOTS)-1:0]  rd_idx,
    output logic [$clog2(SLOTS)-1:0]  cmp_idx
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CTR_W = IDX_W + 1;

    art_pkg::seq_state_t state_reg, state_next;
    logic [CTR_W-1:0]    idx_reg, idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                issue;
    logic                clear_last;
    logic                scan_last;

    assign issue      = (state_reg == art_pkg::SEQ_SCAN) && (idx_reg < CTR_W'(SLOTS));
    assign clear_last = idx_reg[IDX_W-1:0] == IDX_W'(SLOTS - 1);
    assign scan_last  = cmp_valid_reg && (cmp_idx_reg == IDX_W'(SLOTS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            art_pkg::SEQ_CLEAR:
            begin
                if (clear_last)
                    state_next = art_pkg::SEQ_IDLE;
            end
            art_pkg::SEQ_IDLE:
            begin
                if (stat.accept)
                    state_next = art_pkg::SEQ_CHECK;
            end
            art_pkg::SEQ_CHECK:
            begin
                state_next = stat.skip ? art_pkg::SEQ_COMMIT : art_pkg::SEQ_SCAN;
            end
            art_pkg::SEQ_SCAN:
            begin
                if (scan_last)
                    state_next = art_pkg::SEQ_COMMIT;
            end
            art_pkg::SEQ_COMMIT:
            begin
                if (stat.out_free)
                    state_next = art_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = art_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        cmp_valid_next = issue;
        cmp_idx_next   = idx_reg[IDX_W-1:0];
        case (state_reg)
            art_pkg::SEQ_CLEAR:
            begin
                idx_next = clear_last ? '0 : idx_reg + 1'b1;
            end
            art_pkg::SEQ_CHECK:
            begin
                idx_next = '0;
            end
            art_pkg::SEQ_SCAN:
            begin
                if (issue)
                    idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_comb
    begin
        ctrl            = '0;
        ctrl.ready      = state_reg == art_pkg::SEQ_IDLE;
        ctrl.clearing   = state_reg == art_pkg::SEQ_CLEAR;
        ctrl.check      = state_reg == art_pkg::SEQ_CHECK;
        ctrl.scan_issue = issue;
        ctrl.cmp_valid  = cmp_valid_reg;
        ctrl.commit     = state_reg == art_pkg::SEQ_COMMIT;
    end

    assign rd_idx  = idx_reg[IDX_W-1:0];
    assign cmp_idx = cmp_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= art_pkg::SEQ_CLEAR;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
        end
    end

endmodule

@@ rtl/core/address_region_table.sv @@
// Channel    | Dir | Payload             | Handshake
// request    | in  | art_pkg::in_item_t  | valid/ready, item taken when both high
// response   | out | art_pkg::out_item_t | valid/ready, item taken when both high
// cfg        | in  | cfg_index, cfg_data | cfg_we, written on the edge, no stall
//
// Items are taken one at a time: each passes the idle accept step, check, a walk of
// all SLOTS table entries through the single table RAM read port (one slot per
// cycle, read data registered) and commit before the next is accepted. Failed
// enter checks and the reserved action skip the walk.
// After reset the table is swept clear; no item is taken then.
// A stalled response holds the commit step only once a new item has finished.
module address_region_table #(
    parameter int SLOTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    art_stream_if.sink                    request,
    art_stream_if.source                  response,
    input  logic                          cfg_we,
    input  logic [art_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [art_pkg::ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int TOT_W  = $clog2(SLOTS + 1);
    localparam int CNT_W  = art_pkg::CNT_W;
    localparam int ADDR_W = art_pkg::ADDR_W;
    localparam int SLOT_W = $bits(art_pkg::slot_t);

    // Configuration bounds
    logic [ADDR_W-1:0] min_addr_reg;
    logic [ADDR_W-1:0] max_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_addr_reg <= art_pkg::RESET_MIN_ADDRESS;
            max_addr_reg <= art_pkg::RESET_MAX_ADDRESS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                art_pkg::CFG_MIN_ADDRESS: min_addr_reg <= cfg_data;
                art_pkg::CFG_MAX_ADDRESS: max_addr_reg <= cfg_data;
                default:
                begin
                    min_addr_reg <= min_addr_reg;
                end
            endcase
        end
    end

    // Sequencer
    art_pkg::seq_ctrl_t ctrl;
    art_pkg::seq_stat_t stat;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   cmp_idx;

    art_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .stat    (stat),
        .ctrl    (ctrl),
        .rd_idx  (rd_idx),
        .cmp_idx (cmp_idx)
    );

    logic accept;
    logic out_free;
    logic commit_fire;

    assign request.ready = ctrl.ready;
    assign accept        = request.valid && ctrl.ready;

    // Latched item and its wrapped end address
    art_pkg::in_item_t item_reg;
    logic [ADDR_W-1:0] end_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= request.data;
            end_reg  <= request.data.address + request.data.size;
        end
    end

    // Argument checks for enter; a failed enter or the reserved action drops straight to commit
    logic enter_bad;
    logic skip;

    assign enter_bad = (item_reg.size == '0) || (item_reg.address < min_addr_reg)
                    || (end_reg > max_addr_reg) || (end_reg < item_reg.address);
    assign skip = (item_reg.action == art_pkg::ACT_RESERVED)
               || ((item_reg.action == art_pkg::ACT_ENTER) && enter_bad);

    // Table storage
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    art_pkg::slot_t    slot_rd;

    art_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    assign slot_rd = art_pkg::slot_t'(ram_rdata);

    // Shared range compare: point test for lookup, overlap test otherwise
    logic is_lookup;
    logic range_match;
    logic hit;

    assign is_lookup = item_reg.action == art_pkg::ACT_LOOKUP;

    art_cmp u_cmp (
        .lo         (item_reg.address),
        .hi         (is_lookup ? item_reg.address : end_reg),
        .incl       (is_lookup),
        .slot_start (slot_rd.start_addr),
        .slot_end   (slot_rd.end_addr),
        .match      (range_match)
    );

    assign hit = ctrl.cmp_valid && slot_rd.valid && range_match;

    // Scan accumulators
    logic                invalid_reg, invalid_next;
    logic                overlap_reg, overlap_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                found_reg, found_next;
    art_pkg::slot_t      hit_slot_reg, hit_slot_next;
    logic [TOT_W-1:0]    removed_reg, removed_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic                enter_ok;

    assign enter_ok = (item_reg.action == art_pkg::ACT_ENTER) && !invalid_reg
                   && !overlap_reg && free_found_reg;

    always_comb
    begin
        invalid_next    = invalid_reg;
        overlap_next    = overlap_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        found_next      = found_reg;
        hit_slot_next   = hit_slot_reg;
        removed_next    = removed_reg;
        total_next      = total_reg;
        if (ctrl.check)
        begin
            invalid_next    = skip;
            overlap_next    = 1'b0;
            free_found_next = 1'b0;
            found_next      = 1'b0;
            removed_next    = '0;
        end
        else if (ctrl.cmp_valid)
        begin
            case (item_reg.action)
                art_pkg::ACT_ENTER:
                begin
                    if (hit)
                        overlap_next = 1'b1;
                    if (!slot_rd.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx;
                    end
                end
                art_pkg::ACT_LOOKUP:
                begin
                    // Hold the first hit only
                    if (hit && !found_reg)
                    begin
                        found_next    = 1'b1;
                        hit_slot_next = slot_rd;
                    end
                end
                art_pkg::ACT_REMOVE:
                begin
                    if (hit)
                    begin
                        removed_next = removed_reg + 1'b1;
                        total_next   = total_reg - 1'b1;
                    end
                end
                default:
                begin
                    found_next = found_reg;
                end
            endcase
        end
        else if (commit_fire && enter_ok)
        begin
            total_next = total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_reg    <= 1'b0;
            overlap_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            removed_reg    <= '0;
            total_reg      <= '0;
        end
        else
        begin
            invalid_reg    <= invalid_next;
            overlap_reg    <= overlap_next;
            free_found_reg <= free_found_next;
            found_reg      <= found_next;
            removed_reg    <= removed_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        hit_slot_reg <= hit_slot_next;
    end

    // Table writes: clearing sweep, slot drop on remove, new slot on enter
    art_pkg::slot_t new_slot;
    art_pkg::slot_t dropped_slot;

    always_comb
    begin
        new_slot            = '0;
        new_slot.valid      = 1'b1;
        new_slot.start_addr = item_reg.address;
        new_slot.end_addr   = end_reg;
        new_slot.prot       = item_reg.prot;
        new_slot.prot_limit = item_reg.prot_limit;
        new_slot.flags      = item_reg.flags;

        dropped_slot        = slot_rd;
        dropped_slot.valid  = 1'b0;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rd_idx;
        ram_wdata = '0;
        if (ctrl.clearing)
        begin
            ram_we = 1'b1;
        end
        else if (hit && (item_reg.action == art_pkg::ACT_REMOVE))
        begin
            ram_we    = 1'b1;
            ram_waddr = cmp_idx;
            ram_wdata = SLOT_W'(dropped_slot);
        end
        else if (commit_fire && enter_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_reg;
            ram_wdata = SLOT_W'(new_slot);
        end
    end

    // Result and output register
    art_pkg::out_item_t result;
    logic               out_valid_reg, out_valid_next;
    art_pkg::out_item_t out_data_reg;

    assign out_free    = !out_valid_reg || response.ready;
    assign commit_fire = ctrl.commit && out_free;

    always_comb
    begin
        result        = '0;
        result.status = art_pkg::ST_OK;
        if (invalid_reg)
            result.status = art_pkg::ST_INVALID;
        else if ((item_reg.action == art_pkg::ACT_ENTER) && !enter_ok)
            result.status = art_pkg::ST_NOSPACE;
        result.found = found_reg;
        if (found_reg)
        begin
            result.region_start      = hit_slot_reg.start_addr;
            result.region_end        = hit_slot_reg.end_addr;
            result.region_prot       = hit_slot_reg.prot;
            result.region_prot_limit = hit_slot_reg.prot_limit;
            result.region_flags      = hit_slot_reg.flags;
        end
        result.removed_count  = CNT_W'(removed_reg);
        result.occupied_count = CNT_W'(total_next);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit_fire)
            out_valid_next = 1'b1;
        else if (response.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
            out_data_reg <= result;
    end

    assign response.valid = out_valid_reg;
    assign response.data  = out_data_reg;

    always_comb
    begin
        stat          = '0;
        stat.accept   = accept;
        stat.skip     = skip;
        stat.out_free = out_free;
    end

endmodule

@@ rtl/core/art_checker.sv @@
module art_checker #(
    parameter int SLOTS = 256
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input art_pkg::out_item_t rsp_data
);

    // A stalled response holds its item
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response item changed while stalled");

    // One item at a time: no request taken right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.occupied_count <= SLOTS)
        else $error("occupied count beyond table size");

    // Region start, end and flags stay zero without a lookup hit
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.found |->
            rsp_data.region_start == '0 && rsp_data.region_end == '0
            && rsp_data.region_flags == '0)
        else $error("region fields set without a hit");

    // Only a successful remove reports deleted regions
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.removed_count != '0 |->
            rsp_data.status == art_pkg::ST_OK && !rsp_data.found)
        else $error("removed count on a non-remove result");

endmodule

bind address_region_table art_checker #(
    .SLOTS (SLOTS)
) u_art_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .rsp_data  (response.data)
);

@@ dv/tb_address_region_table.sv @@
`timescale 1ns / 100ps

module tb_address_region_table;
    import art_pkg::*;

    localparam int                CLK_PERIOD       = 12;
    localparam int                SLOTS            = 256;
    localparam int                GRID_BYTES       = 256;
    localparam int                GRID_CELLS       = 1024;
    localparam int                LONG_HOLD_AT     = 350;
    localparam int                LONG_HOLD_CYCLES = 2000;
    localparam int                SETTLE_CYCLES    = 8;
    localparam int                PHASES           = 5;
    localparam logic [ADDR_W-1:0] GRID_STEP        = ADDR_W'(GRID_BYTES);
    localparam logic [ADDR_W-1:0] TOP_ADDR         = {ADDR_W{1'b1}};
    // Window for the fill phase: exactly GRID_CELLS cells between the bounds.
    localparam logic [ADDR_W-1:0] WINDOW_LO        = 64'h0000_1234_0000_0000;
    localparam logic [ADDR_W-1:0] WINDOW_HI        = WINDOW_LO + GRID_STEP * GRID_CELLS;
    // Grid whose last cell touches the top of the address space.
    localparam logic [ADDR_W-1:0] HIGH_GRID        = 64'hffff_ffff_fffc_0000;

    // One random phase: bounds to program, where the address grid sits,
    // how many items and the action mix in percent (the rest is reserved).
    typedef struct {
        logic [ADDR_W-1:0] lo_bound;
        logic [ADDR_W-1:0] hi_bound;
        logic [ADDR_W-1:0] grid_base;
        int                items;
        int                enter_pct;
        int                lookup_pct;
        int                remove_pct;
        int                clean_pct;
        bit                sweep;
    } phase_plan_t;

    // Region table mirror plus the queue of results still owed by the block.
    class region_table_scoreboard;
        bit                 slot_used       [SLOTS];
        logic [ADDR_W-1:0]  slot_lo         [SLOTS];
        logic [ADDR_W-1:0]  slot_hi         [SLOTS];
        logic [PROT_W-1:0]  slot_prot       [SLOTS];
        logic [PROT_W-1:0]  slot_prot_limit [SLOTS];
        logic [FLAGS_W-1:0] slot_flags      [SLOTS];
        logic [CNT_W-1:0]   region_total;
        logic [ADDR_W-1:0]  min_addr;
        logic [ADDR_W-1:0]  max_addr;
        out_item_t          awaited_results [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            int i;
            for (i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            region_total = '0;
            min_addr     = RESET_MIN_ADDRESS;
            max_addr     = RESET_MAX_ADDRESS;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_bound(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
            if (index == CFG_MIN_ADDRESS)
                min_addr = value;
            else
                max_addr = value;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function status_t enter_region(in_item_t req);
            logic [ADDR_W-1:0] span_end;
            int                free_idx;
            int                i;
            span_end = req.address + req.size;
            free_idx = -1;
            if (req.size == '0 || req.address < min_addr)
                return ST_INVALID;
            if (span_end > max_addr || span_end < req.address)
                return ST_INVALID;
            for (i = 0; i < SLOTS; i++)
            begin
                if (slot_used[i])
                begin
                    if (req.address < slot_hi[i] && span_end > slot_lo[i])
                        return ST_NOSPACE;
                end
                else if (free_idx < 0)
                    free_idx = i;
            end
            if (free_idx < 0)
                return ST_NOSPACE;
            slot_used[free_idx]       = 1'b1;
            slot_lo[free_idx]         = req.address;
            slot_hi[free_idx]         = span_end;
            slot_prot[free_idx]       = req.prot;
            slot_prot_limit[free_idx] = req.prot_limit;
            slot_flags[free_idx]      = req.flags;
            region_total              = region_total + 1'b1;
            return ST_OK;
        endfunction

        function void note_request(in_item_t req);
            out_item_t         want;
            logic [ADDR_W-1:0] span_end;
            int                i;
            want = '0;
            case (req.action)
                ACT_ENTER:
                    want.status = enter_region(req);
                ACT_LOOKUP:
                begin
                    want.status = ST_OK;
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (slot_used[i] && req.address >= slot_lo[i]
                            && req.address < slot_hi[i])
                        begin
                            want.found             = 1'b1;
                            want.region_start      = slot_lo[i];
                            want.region_end        = slot_hi[i];
                            want.region_prot       = slot_prot[i];
                            want.region_prot_limit = slot_prot_limit[i];
                            want.region_flags      = slot_flags[i];
                            break;
                        end
                    end
                end
                ACT_REMOVE:
                begin
                    want.status = ST_OK;
                    span_end    = req.address + req.size;
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (slot_used[i] && slot_lo[i] < span_end && slot_hi[i] > req.address)
                        begin
                            slot_used[i]       = 1'b0;
                            want.removed_count = want.removed_count + 1'b1;
                            region_total       = region_total - 1'b1;
                        end
                    end
                end
                default:
                    want.status = ST_INVALID;
            endcase
            want.occupied_count = region_total;
            awaited_results.push_back(want);
        endfunction

        task report_mismatch(string field, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
            mismatches++;
            $display("%0t: result %0d, %s: got %h, expected %h",
                     $time, results_seen, field, got, want);
        endtask

        task check_response(out_item_t got);
            out_item_t want;
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result with nothing awaited", got.status, '0);
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.found !== want.found)
                report_mismatch("found", got.found, want.found);
            if (got.region_start !== want.region_start)
                report_mismatch("region_start", got.region_start, want.region_start);
            if (got.region_end !== want.region_end)
                report_mismatch("region_end", got.region_end, want.region_end);
            if (got.region_prot !== want.region_prot)
                report_mismatch("region_prot", got.region_prot, want.region_prot);
            if (got.region_prot_limit !== want.region_prot_limit)
                report_mismatch("region_prot_limit", got.region_prot_limit,
                                want.region_prot_limit);
            if (got.region_flags !== want.region_flags)
                report_mismatch("region_flags", got.region_flags, want.region_flags);
            if (got.removed_count !== want.removed_count)
                report_mismatch("removed_count", got.removed_count, want.removed_count);
            if (got.occupied_count !== want.occupied_count)
                report_mismatch("occupied_count", got.occupied_count, want.occupied_count);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [ADDR_W-1:0]      cfg_data;
    int                     accepted_requests = 0;
    int                     burst_left        = 0;
    bit                     long_hold_done    = 1'b0;
    region_table_scoreboard region_sb;

    art_stream_if #(.T(in_item_t))  request_ch ();
    art_stream_if #(.T(out_item_t)) response_ch ();

    address_region_table #(
        .SLOTS (SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_ch),
        .response  (response_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
        clk = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Sample both channels on the rising edge. Check the result first, then
    // predict the new item; an item never completes on the edge it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (response_ch.valid && response_ch.ready)
                region_sb.check_response(response_ch.data);
            if (request_ch.valid && request_ch.ready)
            begin
                region_sb.note_request(request_ch.data);
                accepted_requests++;
            end
        end
    end

    function automatic in_item_t make_request(action_t act, logic [ADDR_W-1:0] addr,
                                              logic [ADDR_W-1:0] len,
                                              logic [PROT_W-1:0] prot,
                                              logic [PROT_W-1:0] prot_limit,
                                              logic [FLAGS_W-1:0] flags);
        in_item_t req;
        req.action     = act;
        req.address    = addr;
        req.size       = len;
        req.prot       = prot;
        req.prot_limit = prot_limit;
        req.flags      = flags;
        return req;
    endfunction

    // Draw one item for a phase. Clean items sit on the address grid: enters
    // stay within one cell, so they never overlap a neighbor and the table
    // can fill up; lookups and removes land inside or near cells. Rough items
    // probe the bounds, wrap-around, zero and huge sizes.
    function automatic in_item_t random_request(phase_plan_t p);
        in_item_t          req;
        int                roll;
        logic [ADDR_W-1:0] cell_base;
        roll = $urandom_range(0, 99);
        if (roll < p.enter_pct)
            req.action = ACT_ENTER;
        else if (roll < p.enter_pct + p.lookup_pct)
            req.action = ACT_LOOKUP;
        else if (roll < p.enter_pct + p.lookup_pct + p.remove_pct)
            req.action = ACT_REMOVE;
        else
            req.action = ACT_RESERVED;
        req.prot       = PROT_W'($urandom_range(0, 7));
        req.prot_limit = PROT_W'($urandom_range(0, 7));
        req.flags      = $urandom();
        req.size       = {$urandom(), $urandom()};
        cell_base      = p.grid_base + GRID_STEP * ADDR_W'($urandom_range(0, GRID_CELLS - 1));
        if ($urandom_range(0, 99) < p.clean_pct)
        begin
            req.address = cell_base;
            case (req.action)
                ACT_ENTER:
                    req.size = ADDR_W'($urandom_range(1, GRID_BYTES));
                ACT_LOOKUP:
                    req.address = cell_base + $urandom_range(0, GRID_BYTES - 1);
                ACT_REMOVE:
                begin
                    req.address = cell_base + $urandom_range(0, GRID_BYTES - 1);
                    req.size    = ADDR_W'($urandom_range(0, 4 * GRID_BYTES));
                end
                default:
                    ;
            endcase
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                req.address = p.lo_bound - $urandom_range(0, 2);
            else if (roll < 50)
                req.address = p.hi_bound - $urandom_range(0, 2 * GRID_BYTES);
            else if (roll < 70)
                req.address = cell_base + $urandom_range(1, GRID_BYTES - 1);
            else
                req.address = {$urandom(), $urandom()};
            roll = $urandom_range(0, 99);
            if (roll < 20)
                req.size = '0;
            else if (roll < 45)
                req.size = ADDR_W'($urandom_range(1, 16 * GRID_BYTES));
            else if (roll < 60)
                req.size = TOP_ADDR;
            else if (roll < 80)
                req.size = p.hi_bound - req.address + $urandom_range(0, 1);
            // otherwise keep the fully random size
        end
        return req;
    endfunction

    // Offer one item and hold it until taken. Items go out in bursts; after
    // a burst drop valid for a random gap, or keep going back to back.
    task automatic offer(in_item_t req);
        int gap;
        request_ch.valid <= 1'b1;
        request_ch.data  <= req;
        do
            @(posedge clk);
        while (!request_ch.ready);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
            if (gap > 0)
            begin
                request_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        request_ch.valid <= 1'b0;
        while (region_sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both bounds on back-to-back edges; only called with the block idle.
    task automatic program_bounds(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_ADDRESS;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_MAX_ADDRESS;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        region_sb.set_bound(CFG_MIN_ADDRESS, lo);
        region_sb.set_bound(CFG_MAX_ADDRESS, hi);
    endtask

    // Response side: ready runs of random length, broken by stalls. Once,
    // well into the fill phase, hold off long enough for the block to back
    // up and stall its request side.
    initial
    begin : response_pacing
        int run_len;
        int stall_len;
        response_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            run_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(600, 2500)
                                                    : $urandom_range(1, 200);
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            response_ch.ready <= 1'b1;
            repeat (run_len) @(negedge clk);
            if (!long_hold_done && accepted_requests >= LONG_HOLD_AT)
            begin
                stall_len      = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (stall_len > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall_len) @(negedge clk);
            end
        end
    end

    initial
    begin : stimulus
        phase_plan_t       plans [PHASES];
        logic [ADDR_W-1:0] low_base;
        int                p;
        int                n;
        region_sb        = new();
        request_ch.valid = 1'b0;
        request_ch.data  = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_MIN_ADDRESS;
        cfg_data         = '0;
        rst_n            = 1'b0;
        low_base         = RESET_MIN_ADDRESS;

        // Open bounds around a grid at zero; mixed traffic.
        plans[0] = '{64'h0, TOP_ADDR, 64'h0, 200, 45, 30, 22, 70, 1'b0};
        // Tight window, enter-heavy: fill the table and run into the full case.
        plans[1] = '{WINDOW_LO, WINDOW_HI, WINDOW_LO, 420, 90, 8, 1, 93, 1'b1};
        // Same window, remove-heavy: punch holes and refill them.
        plans[2] = '{WINDOW_LO, WINDOW_HI, WINDOW_LO, 250, 30, 30, 38, 80, 1'b0};
        // Inverted bounds: every enter is rejected, lookups still hit.
        plans[3] = '{TOP_ADDR, 64'h0, WINDOW_LO, 60, 40, 30, 28, 60, 1'b0};
        // Reset bounds, grid at the very top: end-at-max and wrap cases.
        plans[4] = '{RESET_MIN_ADDRESS, RESET_MAX_ADDRESS, HIGH_GRID, 320, 45, 30, 22, 70, 1'b0};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items under the reset bounds. The first one also waits out
        // the clearing sweep after reset.
        // Lookup and remove on an empty table.
        offer(make_request(ACT_LOOKUP, '0, '0, 3'd0, 3'd0, '0));
        offer(make_request(ACT_REMOVE, '0, TOP_ADDR, 3'd0, 3'd0, '0));
        // Enter with zero size, and one starting just below the lower bound.
        offer(make_request(ACT_ENTER, low_base, '0, 3'd1, 3'd1, '0));
        offer(make_request(ACT_ENTER, low_base - 1, 64'h10, 3'd1, 3'd1, '0));
        // Good enter with all rights and flags set, then an overlapping one.
        offer(make_request(ACT_ENTER, low_base, 64'h1000, 3'd7, 3'd7, 32'hffff_ffff));
        offer(make_request(ACT_ENTER, low_base + 64'h800, 64'h1000, 3'd3, 3'd3, '0));
        // Adjacent region: ranges are half-open, so this one fits.
        offer(make_request(ACT_ENTER, low_base + 64'h1000, 64'h1000, 3'd0, 3'd0, '0));
        // End wraps past the top, then an end exactly at the upper bound and one just past it.
        offer(make_request(ACT_ENTER, TOP_ADDR - 64'hff, 64'h200, 3'd1, 3'd1, '0));
        offer(make_request(ACT_ENTER, TOP_ADDR - 64'h100, 64'h100, 3'd5, 3'd2, 32'ha5a5_5a5a));
        offer(make_request(ACT_ENTER, TOP_ADDR - 64'h100, 64'h101, 3'd5, 3'd2, '0));
        // Lookups at both edges of the stored regions.
        offer(make_request(ACT_LOOKUP, low_base, '0, 3'd0, 3'd0, '0));
        offer(make_request(ACT_LOOKUP, low_base + 64'h1fff, '0, 3'd0, 3'd0, '0));
        offer(make_request(ACT_LOOKUP, low_base + 64'h2000, '0, 3'd0, 3'd0, '0));
        offer(make_request(ACT_LOOKUP, TOP_ADDR, '0, 3'd0, 3'd0, '0));
        offer(make_request(ACT_LOOKUP, TOP_ADDR - 1, '0, 3'd0, 3'd0, '0));
        // Reserved action code with arbitrary fields.
        offer(make_request(ACT_RESERVED, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                           3'd7, 3'd7, $urandom()));
        // Remove whose range wraps: matches nothing.
        offer(make_request(ACT_REMOVE, TOP_ADDR, 64'h2, 3'd0, 3'd0, '0));
        // Zero-size remove strictly inside a region still deletes it.
        offer(make_request(ACT_REMOVE, low_base + 64'h800, '0, 3'd0, 3'd0, '0));
        // Remove straddling the old boundary deletes the second region; only the top one is left.
        offer(make_request(ACT_REMOVE, low_base + 64'hfff, 64'h2, 3'd0, 3'd0, '0));
        // Refill the lowest free slot and look it up.
        offer(make_request(ACT_ENTER, low_base, 64'h10, 3'd6, 3'd4, 32'h0000_ffff));
        offer(make_request(ACT_LOOKUP, low_base + 64'hf, '0, 3'd0, 3'd0, '0));
        // Full-width size wraps the end below the start.
        offer(make_request(ACT_ENTER, low_base, TOP_ADDR, 3'd1, 3'd1, '0));
        // Remove everything that is left.
        offer(make_request(ACT_REMOVE, '0, TOP_ADDR, 3'd0, 3'd0, '0));

        // Random phases. Between phases drain all results, then reprogram the
        // bounds while the block is idle.
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            program_bounds(plans[p].lo_bound, plans[p].hi_bound);
            if (plans[p].sweep)
                offer(make_request(ACT_REMOVE, '0, TOP_ADDR, 3'd0, 3'd0, '0));
            for (n = 0; n < plans[p].items; n++)
                offer(random_request(plans[p]));
        end

        // Let the last results arrive, then watch for stray ones a while.
        drain_results();
        repeat (SLOTS + SETTLE_CYCLES) @(negedge clk);
        if (region_sb.mismatches == 0 && region_sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop: several times the slowest legal run (every item with the
    // longest sender gap, full table walk and longest response stall).
    initial
    begin : watchdog
        #60_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/art_pkg.sv
rtl/core/art_stream_if.sv
rtl/core/art_ram.sv
rtl/core/art_cmp.sv
rtl/core/art_seq.sv
rtl/core/address_region_table.sv
rtl/core/art_checker.sv
dv/tb_address_region_table.sv
